// ===== src/sorted_equal_range_search_core_macros.svh =====
// ----------------------------------------------------------------------------
// sorted_equal_range_search_core assertion macros
// clocked property helpers shared by the checker
// ----------------------------------------------------------------------------
`ifndef SORTED_EQUAL_RANGE_SEARCH_CORE_MACROS_SVH
`define SORTED_EQUAL_RANGE_SEARCH_CORE_MACROS_SVH

// same-cycle implication, disabled while in reset
`define SERS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define SERS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/sers_pkg.sv =====
// ----------------------------------------------------------------------------
// sers_pkg
// shared constants and types of the equal-range search core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sers_pkg;

  localparam int DEPTH       = 1024;
  localparam int VALUE_WIDTH = 32;
  localparam int ADDR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int IDX_W       = 10;
  localparam int OP_W        = 2;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 2'd0,
    OP_QUERY  = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] first_index;
    logic [IDX_W-1:0] last_index;
  } res_t;

  typedef struct packed {
    logic                          we;
    logic [ADDR_W-1:0]             addr;
    logic signed [VALUE_WIDTH-1:0] wdata;
  } mem_req_t;

endpackage

// ===== src/sers_ifs.sv =====
// ----------------------------------------------------------------------------
// sers channel interfaces
// valid/ready channels for search requests and results
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sers_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        operation;
  logic signed [31:0] value;

  modport source (output valid, operation, value, input ready);
  modport sink   (input valid, operation, value, output ready);
endinterface

interface sers_out_if;
  logic       valid;
  logic       ready;
  logic       found;
  logic [9:0] first_index;
  logic [9:0] last_index;

  modport source (output valid, found, first_index, last_index, input ready);
  modport sink   (input valid, found, first_index, last_index, output ready);
endinterface

// ===== src/sers_ram.sv =====
// ----------------------------------------------------------------------------
// sers_ram
// single-port synchronous ram, registered read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sers_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                             wdata,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/sers_ctrl.sv =====
// ----------------------------------------------------------------------------
// sers_ctrl
// sequencer: append, clear, binary search probe loop and neighbor scan
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sers_ctrl import sers_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [OP_W-1:0]               in_op,
  input  logic signed [VALUE_WIDTH-1:0] in_value,
  input  logic                          out_free,
  output logic                          res_valid,
  output res_t                          res,
  output mem_req_t                      mem_req,
  input  logic signed [VALUE_WIDTH-1:0] mem_rdata
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SRCH  = 5'b00010,
    S_SCANL = 5'b00100,
    S_SCANR = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t                        state_r, state_nxt;
  logic [CNT_W-1:0]              count_r, count_nxt;
  logic signed [VALUE_WIDTH-1:0] key_r, key_nxt;
  logic [CNT_W:0]                left_r, left_nxt;
  logic [CNT_W:0]                right_r, right_nxt;
  logic [ADDR_W-1:0]             mid_r, mid_nxt;
  logic [ADDR_W-1:0]             lo_r, lo_nxt;
  logic [ADDR_W-1:0]             hi_r, hi_nxt;
  res_t                          res_r, res_nxt;

  logic [CNT_W:0]    mid_w, la, rb, mid_a, mid_b, cnt_m1;
  logic [ADDR_W-1:0] lo_v, hi_v, rfrom;
  logic              go_right, fin;

  // candidate next probes for both outcomes, chosen by the compare
  assign mid_w  = (CNT_W + 1)'(mid_r);
  assign la     = mid_w + 1'b1;
  assign rb     = mid_w - 1'b1;
  assign mid_a  = la + ((right_r - la) >> 1);
  assign mid_b  = left_r + ((rb - left_r) >> 1);
  assign cnt_m1 = (CNT_W + 1)'(count_r) - 1'b1;

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    key_nxt   = key_r;
    left_nxt  = left_r;
    right_nxt = right_r;
    mid_nxt   = mid_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    res_nxt   = res_r;
    mem_req   = '0;
    lo_v      = lo_r;
    hi_v      = hi_r;
    rfrom     = hi_r;
    go_right  = 1'b0;
    fin       = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          key_nxt   = in_value;
          res_nxt   = '0;
          state_nxt = S_DONE;
          case (op_t'(in_op))
            OP_APPEND: begin
              if (count_r < CNT_W'(DEPTH)) begin
                mem_req.we    = 1'b1;
                mem_req.addr  = count_r[ADDR_W-1:0];
                mem_req.wdata = in_value;
                count_nxt     = count_r + 1'b1;
                res_nxt.found = 1'b1;
              end
            end
            OP_CLEAR: begin
              count_nxt = '0;
            end
            OP_QUERY: begin
              if (count_r != '0) begin
                left_nxt     = '0;
                right_nxt    = cnt_m1;
                mid_nxt      = ADDR_W'(cnt_m1 >> 1);
                mem_req.addr = ADDR_W'(cnt_m1 >> 1);
                state_nxt    = S_SRCH;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_SRCH: begin
        if (mem_rdata == key_r) begin
          lo_v   = mid_r;
          hi_v   = mid_r;
          lo_nxt = mid_r;
          hi_nxt = mid_r;
          if (mid_r != '0) begin
            mem_req.addr = mid_r - 1'b1;
            state_nxt    = S_SCANL;
          end else begin
            go_right = 1'b1;
            rfrom    = mid_r;
          end
        end else if (mem_rdata < key_r) begin
          left_nxt = la;
          if ($signed(la) > $signed(right_r)) begin
            state_nxt = S_DONE;
          end else begin
            mid_nxt      = ADDR_W'(mid_a);
            mem_req.addr = ADDR_W'(mid_a);
          end
        end else begin
          right_nxt = rb;
          if ($signed(left_r) > $signed(rb)) begin
            state_nxt = S_DONE;
          end else begin
            mid_nxt      = ADDR_W'(mid_b);
            mem_req.addr = ADDR_W'(mid_b);
          end
        end
      end

      // read data holds entry lo-1
      S_SCANL: begin
        rfrom    = hi_r;
        go_right = 1'b1;
        if (mem_rdata == key_r) begin
          lo_v   = lo_r - 1'b1;
          lo_nxt = lo_v;
          if (lo_v != '0) begin
            mem_req.addr = lo_v - 1'b1;
            go_right     = 1'b0;
          end
        end
      end

      // read data holds entry hi+1
      S_SCANR: begin
        if (mem_rdata == key_r) begin
          hi_v   = hi_r + 1'b1;
          hi_nxt = hi_v;
          rfrom  = hi_v;
          if (CNT_W'(hi_v) + 1'b1 < count_r) begin
            mem_req.addr = hi_v + 1'b1;
          end else begin
            fin = 1'b1;
          end
        end else begin
          fin = 1'b1;
        end
      end

      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (go_right) begin
      if (CNT_W'(rfrom) + 1'b1 < count_r) begin
        mem_req.addr = rfrom + 1'b1;
        state_nxt    = S_SCANR;
      end else begin
        fin = 1'b1;
      end
    end

    if (fin) begin
      res_nxt.found       = 1'b1;
      res_nxt.first_index = IDX_W'(lo_v);
      res_nxt.last_index  = IDX_W'(hi_v);
      state_nxt           = S_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    left_r  <= left_nxt;
    right_r <= right_nxt;
    mid_r   <= mid_nxt;
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    res_r   <= res_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

endmodule

// ===== src/sorted_equal_range_search_core.sv =====
// append, clear and unknown codes pass through the sequencer's result register and the
// DONE state into the output register; a query runs P binary search probes (at most
// log2(DEPTH)+1, 11 here), then S neighbor reads (equal run plus up to one stop read per side)
// one ram read per cycle sets the pace; one item at a time, the next input transfer can
// come at the earliest in the cycle after the result leaves the sequencer
// reset: synchronous active-low, empties the table (count zero), no clearing pass
// ----------------------------------------------------------------------------
// sorted_equal_range_search_core
// sorted table with append, clear and equal-range binary search
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_equal_range_search_core import sers_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  sers_in_if.sink    in_chan,
  sers_out_if.source out_chan
);

  mem_req_t                      mem_req;
  logic signed [VALUE_WIDTH-1:0] mem_rdata;
  logic                          res_valid;
  res_t                          res;
  logic                          out_free;
  logic                          out_valid_r;
  res_t                          out_res_r;

  sers_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .addr  (mem_req.addr),
    .wdata (mem_req.wdata),
    .rdata (mem_rdata)
  );

  sers_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .in_op     (in_chan.operation),
    .in_value  (in_chan.value),
    .out_free  (out_free),
    .res_valid (res_valid),
    .res       (res),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  // output register decouples the sequencer from the result transfer
  assign out_free = !out_valid_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.found       = out_res_r.found;
  assign out_chan.first_index = out_res_r.first_index;
  assign out_chan.last_index  = out_res_r.last_index;

endmodule

// ===== src/sers_chk.sv =====
// ----------------------------------------------------------------------------
// sers_chk
// port-level checks of the equal-range search core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sorted_equal_range_search_core_macros.svh"

module sers_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_found,
  input logic [9:0] out_first_index,
  input logic [9:0] out_last_index
);

  // one item at a time: ready drops after an input transfer
  `SERS_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "input taken while busy")

  `SERS_ASSERT_IMPL(a_miss_zero, out_valid && !out_found,
                    out_first_index == 10'd0 && out_last_index == 10'd0,
                    "miss with nonzero index")

  `SERS_ASSERT_IMPL(a_range_order, out_valid, out_first_index <= out_last_index,
                    "first index above last index")

  `SERS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped")

endmodule

bind sorted_equal_range_search_core sers_chk u_sers_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_chan.valid),
  .in_ready        (in_chan.ready),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .out_found       (out_chan.found),
  .out_first_index (out_chan.first_index),
  .out_last_index  (out_chan.last_index)
);

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb - equal-range search core testbench
// directed table of appends, queries, clears and reserved codes, then random
// sorted and unsorted sets with queries, and one fill past capacity; every
// result is checked in order against a table value or a behavioral search model
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import sers_pkg::*;

  localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;
  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;
  localparam int SMALL_SET_ITEMS = 400;
  localparam int HOLD_CYCLES     = 400;
  localparam int DRAIN_CYCLES    = 100;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic signed [31:0] value;
    bit                 exact;
    res_t               want;
  } dir_row_t;

  logic clk;
  logic rst_n;

  sers_in_if  in_if ();
  sers_out_if out_if ();

  sorted_equal_range_search_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  // search model state
  logic signed [VALUE_WIDTH-1:0] model_table [DEPTH];
  int                            model_count = 0;

  res_t               expected_results [$];
  dir_row_t           dir_rows [$];
  logic signed [31:0] set_vals [$];

  int err_count     = 0;
  int items_sent    = 0;
  int hold_requests = 0;
  int hold_served   = 0;
  int hold_left     = 0;
  bit no_idle       = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic report_error(string msg);
    $display("ERROR @%0t: %s", $time, msg);
    err_count++;
  endtask

  function automatic res_t predict_step(logic [OP_W-1:0] op, logic signed [31:0] val);
    res_t r;
    int   left, right, mid, hit, lo, hi;
    r = '0;
    case (op)
      OP_APPEND: begin
        if (model_count < DEPTH) begin
          model_table[model_count] = val;
          model_count++;
          r.found = 1'b1;
        end
      end
      OP_CLEAR: model_count = 0;
      OP_QUERY: begin
        left  = 0;
        right = model_count - 1;
        hit   = -1;
        while (left <= right && hit < 0) begin
          mid = left + (right - left) / 2;
          if (model_table[mid] == val) hit = mid;
          else if (model_table[mid] < val) left = mid + 1;
          else right = mid - 1;
        end
        if (hit >= 0) begin
          lo = hit;
          hi = hit;
          while (lo > 0 && model_table[lo-1] == model_table[hit]) lo--;
          while (hi + 1 < model_count && model_table[hi+1] == model_table[hit]) hi++;
          r.found       = 1'b1;
          r.first_index = lo[IDX_W-1:0];
          r.last_index  = hi[IDX_W-1:0];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_item(logic [OP_W-1:0] op, logic signed [31:0] val,
                           bit exact = 1'b0, res_t want = '0);
    res_t pred;
    while (!no_idle && $urandom_range(99) < 30) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.operation <= op;
    in_if.value     <= val;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    pred = predict_step(op, val);
    expected_results.push_back(exact ? want : pred);
    if (op != OP_RESERVED) items_sent++;
  endtask

  task automatic add_row(logic [OP_W-1:0] op, logic signed [31:0] val, bit exact,
                         logic found = 1'b0, int first = 0, int last = 0);
    dir_row_t row;
    row.op                = op;
    row.value             = val;
    row.exact             = exact;
    row.want.found        = found;
    row.want.first_index  = first[IDX_W-1:0];
    row.want.last_index   = last[IDX_W-1:0];
    dir_rows.push_back(row);
  endtask

  // ascending values into set_vals: dense duplicates, mid-size steps, or
  // steps spread over the whole signed range
  task automatic build_run(int n, int mode);
    longint      cur;
    int          seed_val;
    int unsigned step_max;
    set_vals.delete();
    seed_val = $urandom;
    case (mode)
      0: begin cur = seed_val; step_max = 1; end
      1: begin cur = seed_val; step_max = 1000; end
      default: begin
        cur      = longint'(VAL_MIN) + $urandom_range(3);
        step_max = 32'hffff_ffff / (n + 1);
      end
    endcase
    for (int i = 0; i < n; i++) begin
      if (cur > longint'(VAL_MAX)) cur = VAL_MAX;
      set_vals.push_back(cur[31:0]);
      cur += $urandom_range(step_max);
    end
  endtask

  function automatic logic signed [31:0] pick_target();
    int k;
    int idx;
    logic signed [31:0] t;
    k = $urandom_range(99);
    t = $urandom;
    if (set_vals.size() > 0) begin
      idx = $urandom_range(set_vals.size() - 1);
      if (k < 60) t = set_vals[idx];
      else if (k < 75) t = set_vals[idx] + ($urandom_range(1) ? 1 : -1);
    end
    if (k >= 75 && k < 82) t = k[0] ? VAL_MAX : VAL_MIN;
    return t;
  endfunction

  task automatic check_result();
    res_t want;
    if (expected_results.size() == 0) begin
      report_error($sformatf("result with nothing pending: found=%0b first=%0d last=%0d",
                             out_if.found, out_if.first_index, out_if.last_index));
      return;
    end
    want = expected_results.pop_front();
    if (out_if.found !== want.found)
      report_error($sformatf("found got %0b want %0b", out_if.found, want.found));
    if (out_if.first_index !== want.first_index)
      report_error($sformatf("first_index got %0d want %0d",
                             out_if.first_index, want.first_index));
    if (out_if.last_index !== want.last_index)
      report_error($sformatf("last_index got %0d want %0d",
                             out_if.last_index, want.last_index));
  endtask

  // result side: random backpressure plus a long hold-off when requested
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready) check_result();
      if (hold_served != hold_requests) begin
        hold_left   = HOLD_CYCLES;
        hold_served = hold_requests;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= no_idle || ($urandom_range(99) >= 30);
      end
    end
  end

  initial begin
    int n;
    int nq;
    int k;
    int set_no;
    rst_n           = 1'b0;
    in_if.valid     = 1'b0;
    in_if.operation = OP_APPEND;
    in_if.value     = '0;

    // empty table, extremes, duplicate run, absent targets, reserved code,
    // unsorted appends, clear
    add_row(OP_QUERY, 0, 1);
    add_row(OP_QUERY, VAL_MIN, 1);
    add_row(OP_CLEAR, 0, 1);
    add_row(OP_RESERVED, -1, 1);
    add_row(OP_APPEND, VAL_MIN, 1, 1'b1);
    add_row(OP_APPEND, -1, 1, 1'b1);
    add_row(OP_APPEND, 0, 1, 1'b1);
    add_row(OP_APPEND, 0, 1, 1'b1);
    add_row(OP_APPEND, 0, 1, 1'b1);
    add_row(OP_APPEND, VAL_MAX, 1, 1'b1);
    add_row(OP_QUERY, 0, 1, 1'b1, 2, 4);
    add_row(OP_QUERY, VAL_MIN, 1, 1'b1, 0, 0);
    add_row(OP_QUERY, VAL_MAX, 1, 1'b1, 5, 5);
    add_row(OP_QUERY, -1, 0);
    add_row(OP_QUERY, 1, 1);
    add_row(OP_QUERY, 32'sh5555_5555, 1);
    add_row(OP_RESERVED, 32'shaaaa_aaaa, 1);
    add_row(OP_QUERY, 0, 0);
    add_row(OP_APPEND, 5, 1, 1'b1);
    add_row(OP_APPEND, -7, 1, 1'b1);
    add_row(OP_QUERY, -7, 0);
    add_row(OP_QUERY, 5, 0);
    add_row(OP_CLEAR, 0, 1);
    add_row(OP_QUERY, 0, 1);
    add_row(OP_APPEND, 0, 1, 1'b1);
    add_row(OP_QUERY, 0, 1, 1'b1, 0, 0);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i])
      send_item(dir_rows[i].op, dir_rows[i].value, dir_rows[i].exact, dir_rows[i].want);

    // receiver stalls for a long stretch while items keep coming
    hold_requests++;

    set_no = 0;
    while (items_sent < SMALL_SET_ITEMS) begin
      no_idle = (set_no >= 10 && set_no < 20);
      k = $urandom_range(99);
      if (k < 85) begin
        n = $urandom_range(40);
        build_run(n, $urandom_range(2));
        // some sets go in out of order
        if (k < 9 && n > 1) begin
          repeat (3) set_vals.shuffle();
        end
        send_item(OP_CLEAR, $urandom);
        foreach (set_vals[i]) send_item(OP_APPEND, set_vals[i]);
        nq = $urandom_range(1, 12);
        repeat (nq) begin
          if ($urandom_range(99) < 5) send_item(OP_RESERVED, $urandom);
          send_item(OP_QUERY, pick_target());
        end
      end else begin
        repeat ($urandom_range(1, 8)) send_item($urandom_range(3), $urandom);
      end
      set_no++;
    end
    no_idle = 1'b0;

    // fill to capacity, push past it, search the full table, then clear and query again
    send_item(OP_CLEAR, $urandom);
    build_run(DEPTH, $urandom_range(1));
    foreach (set_vals[i]) begin
      no_idle = (i >= 300 && i < 600);
      if (i == 700) hold_requests++;
      send_item(OP_APPEND, set_vals[i]);
    end
    no_idle = 1'b0;
    repeat (4) send_item(OP_APPEND, $urandom);
    send_item(OP_QUERY, set_vals[DEPTH-1]);
    send_item(OP_QUERY, set_vals[0]);
    repeat (30) send_item(OP_QUERY, pick_target());
    send_item(OP_CLEAR, $urandom);
    send_item(OP_QUERY, set_vals[0]);

    in_if.valid <= 1'b0;
    while (expected_results.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
